@@ hdl/pfba_pkg.sv @@
`default_nettype none

package pfba_pkg;

	// Frame map geometry. FRAME_BYTES is a power of two.
	localparam int NUM_FRAMES   = 1024;
	localparam int FRAME_BYTES  = 4096;
	localparam int WORD_BITS    = 32;
	localparam int MAP_WORDS    = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_IDX_W    = $clog2(WORD_BITS);
	localparam int FRAME_IDX_W  = WORD_IDX_W + BIT_IDX_W;
	localparam int PAGE_SHIFT   = $clog2(FRAME_BYTES);
	localparam int REQ_ADDR_W   = 32;
	localparam int FRAME_ADDR_W = 22;
	localparam int ADDR_WIDE_W  = FRAME_IDX_W + PAGE_SHIFT + FRAME_ADDR_W;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef struct packed {
		logic                  req_type;
		logic [REQ_ADDR_W-1:0] free_addr;
	} pfba_req_t;

	typedef struct packed {
		logic [FRAME_ADDR_W-1:0] frame_addr;
		logic                    granted;
	} pfba_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_FIRST,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_DONE
	} pfba_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic scan_start;
		logic scan_rd;
		logic free_rd;
		logic alloc_wr;
		logic free_wr;
		logic res_grant;
		logic res_zero;
	} pfba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_free;
		logic hit;
		logic last_word;
		logic free_ok;
	} pfba_sts_t;

endpackage

`default_nettype wire

@@ hdl/page_frame_bitmap_allocator.sv @@
// Page frame allocator with one used bit per physical frame.
// Request channel (req_valid/req_ready/req): each transaction is either an
// allocate, which returns the lowest free frame from frame 1 upward and marks
// it used, or a free, which clears the bit of the frame holding req.free_addr.
// Frees of frame 0 or of frames past the end of the map are ignored.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one transaction per
// request; rsp.granted is set only for a successful allocate, and
// rsp.frame_addr is zero for a failed allocate and for every free.
// An allocate scans the map one 32-frame word per cycle through the
// single read port of the map memory. A free is a read-modify-write.
// One request is in flight at a time; the next request can be taken in
// the cycle after the previous response is loaded into the output register.
// Reset marks frame 0 used and every other frame free at once, without a
// clearing pass. If the receiver stalls, the response waits in the output
// register and a finished next response waits until that register empties.
`default_nettype none

module page_frame_bitmap_allocator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire pfba_pkg::pfba_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output pfba_pkg::pfba_rsp_t      rsp
);

	pfba_pkg::pfba_cmd_t cmd;
	pfba_pkg::pfba_sts_t sts;
	pfba_pkg::pfba_rsp_t res;
	pfba_pkg::pfba_rsp_t rsp_q;
	logic                rsp_valid_q;
	logic                rsp_load;
	logic                out_free;

	// The output register can take a new response when it is empty or
	// when its current response leaves in this cycle.
	assign out_free = !rsp_valid_q || rsp_ready;

	pfba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.out_free  (out_free),
		.rsp_load  (rsp_load),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfba_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A granted frame is never the reserved frame 0.
	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.granted |-> rsp.frame_addr != '0)
		else $error("granted response carries frame address zero");

	// Every response without a grant carries address zero.
	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.frame_addr == '0)
		else $error("response without grant carries a nonzero address");

	// Only one request is in flight: the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

endmodule

`default_nettype wire

@@ hdl/pfba_ctrl.sv @@
`default_nettype none

module pfba_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire logic             out_free,
	output logic                  rsp_load,
	input  wire pfba_pkg::pfba_sts_t sts,
	output pfba_pkg::pfba_cmd_t   cmd
);

	pfba_pkg::pfba_state_t state_q;
	pfba_pkg::pfba_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfba_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = sts.in_is_free ? pfba_pkg::ST_FREE_RD : pfba_pkg::ST_SCAN_FIRST;
				end
			end
			pfba_pkg::ST_SCAN_FIRST: begin
				state_d = pfba_pkg::ST_SCAN;
			end
			pfba_pkg::ST_SCAN: begin
				if (sts.hit || sts.last_word) begin
					state_d = pfba_pkg::ST_DONE;
				end
			end
			pfba_pkg::ST_FREE_RD: begin
				state_d = pfba_pkg::ST_FREE_WR;
			end
			pfba_pkg::ST_FREE_WR: begin
				state_d = pfba_pkg::ST_DONE;
			end
			pfba_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pfba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfba_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			pfba_pkg::ST_IDLE: begin
				req_ready      = 1'b1;
				cmd.load_req   = req_valid;
				cmd.scan_start = req_valid;
			end
			pfba_pkg::ST_SCAN_FIRST: begin
				cmd.scan_rd = 1'b1;
			end
			pfba_pkg::ST_SCAN: begin
				if (sts.hit) begin
					cmd.alloc_wr  = 1'b1;
					cmd.res_grant = 1'b1;
				end else if (sts.last_word) begin
					cmd.res_zero = 1'b1;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			pfba_pkg::ST_FREE_RD: begin
				cmd.free_rd = sts.free_ok;
			end
			pfba_pkg::ST_FREE_WR: begin
				cmd.free_wr  = sts.free_ok;
				cmd.res_zero = 1'b1;
			end
			pfba_pkg::ST_DONE: begin
				rsp_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/pfba_datapath.sv @@
`default_nettype none

module pfba_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfba_pkg::pfba_req_t req,
	input  wire pfba_pkg::pfba_cmd_t cmd,
	output pfba_pkg::pfba_sts_t      sts,
	output pfba_pkg::pfba_rsp_t      res
);

	// Frame map storage; one bit per frame, set means used.
	logic [pfba_pkg::WORD_BITS-1:0] mem [pfba_pkg::MAP_WORDS];
	logic [pfba_pkg::MAP_WORDS-1:0] word_valid_q;

	pfba_pkg::pfba_req_t              req_q;
	logic [pfba_pkg::WORD_IDX_W-1:0]  rd_idx_q;
	logic [pfba_pkg::WORD_IDX_W-1:0]  chk_idx_q;
	logic [pfba_pkg::WORD_BITS-1:0]   mem_rd_q;
	logic                             rd_valid_q;
	logic                             rd_zero_q;
	pfba_pkg::pfba_rsp_t              res_q;

	logic [pfba_pkg::REQ_ADDR_W-1:0]  free_frame;
	logic [pfba_pkg::WORD_IDX_W-1:0]  free_word;
	logic [pfba_pkg::BIT_IDX_W-1:0]   free_bit;
	logic [pfba_pkg::WORD_IDX_W-1:0]  rd_addr;
	logic                             rd_en;
	logic                             mem_we;
	logic [pfba_pkg::WORD_BITS-1:0]   rd_data;
	logic [pfba_pkg::WORD_BITS-1:0]   beyond_mask;
	logic [pfba_pkg::WORD_BITS-1:0]   free_vec;
	logic [pfba_pkg::WORD_BITS-1:0]   lowest_free;
	logic [pfba_pkg::BIT_IDX_W-1:0]   hit_bit;
	logic [pfba_pkg::WORD_BITS-1:0]   wr_data;
	logic [pfba_pkg::ADDR_WIDE_W-1:0] addr_wide;

	// Frame index of a free request; the offset inside the page is dropped.
	assign free_frame = req_q.free_addr >> pfba_pkg::PAGE_SHIFT;
	assign free_word  = free_frame[pfba_pkg::FRAME_IDX_W-1:pfba_pkg::BIT_IDX_W];
	assign free_bit   = free_frame[pfba_pkg::BIT_IDX_W-1:0];

	assign rd_en   = cmd.scan_rd | cmd.free_rd;
	assign rd_addr = cmd.free_rd ? free_word : rd_idx_q;
	assign mem_we  = cmd.alloc_wr | cmd.free_wr;

	// A word never written still holds its reset pattern: frame 0 used, rest free.
	assign rd_data = rd_valid_q ? mem_rd_q :
		(rd_zero_q ? pfba_pkg::WORD_BITS'(1) : '0);

	// Bits past the last frame of a partial final word count as used.
	always_comb begin
		logic [pfba_pkg::FRAME_IDX_W:0] fidx;
		beyond_mask = '0;
		for (int b = 0; b < pfba_pkg::WORD_BITS; b++) begin
			fidx = {1'b0, chk_idx_q, pfba_pkg::BIT_IDX_W'(b)};
			beyond_mask[b] = (fidx >= (pfba_pkg::FRAME_IDX_W + 1)'(pfba_pkg::NUM_FRAMES));
		end
	end

	assign free_vec    = ~(rd_data | beyond_mask);
	assign lowest_free = free_vec & (~free_vec + pfba_pkg::WORD_BITS'(1));

	always_comb begin
		hit_bit = '0;
		for (int b = 0; b < pfba_pkg::WORD_BITS; b++) begin
			if (lowest_free[b]) begin
				hit_bit = hit_bit | pfba_pkg::BIT_IDX_W'(b);
			end
		end
	end

	assign addr_wide = pfba_pkg::ADDR_WIDE_W'({chk_idx_q, hit_bit}) << pfba_pkg::PAGE_SHIFT;

	always_comb begin
		if (cmd.free_wr) begin
			wr_data = rd_data & ~(pfba_pkg::WORD_BITS'(1) << free_bit);
		end else begin
			wr_data = rd_data | lowest_free;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[chk_idx_q] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= '0;
			rd_idx_q     <= '0;
			chk_idx_q    <= '0;
			rd_valid_q   <= 1'b0;
			rd_zero_q    <= 1'b0;
		end else begin
			if (mem_we) begin
				word_valid_q[chk_idx_q] <= 1'b1;
			end
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				rd_idx_q <= rd_idx_q + pfba_pkg::WORD_IDX_W'(1);
			end
			if (rd_en) begin
				chk_idx_q  <= rd_addr;
				rd_valid_q <= word_valid_q[rd_addr];
				rd_zero_q  <= (rd_addr == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.res_grant) begin
			res_q.frame_addr <= addr_wide[pfba_pkg::FRAME_ADDR_W-1:0];
			res_q.granted    <= 1'b1;
		end else if (cmd.res_zero) begin
			res_q.frame_addr <= '0;
			res_q.granted    <= 1'b0;
		end
	end

	assign res = res_q;

	assign sts.in_is_free = (req.req_type == pfba_pkg::REQ_FREE);
	assign sts.hit        = |free_vec;
	assign sts.last_word  = (chk_idx_q == pfba_pkg::WORD_IDX_W'(pfba_pkg::MAP_WORDS - 1));
	assign sts.free_ok    = (free_frame != '0) &&
		(free_frame < pfba_pkg::REQ_ADDR_W'(pfba_pkg::NUM_FRAMES));

endmodule

`default_nettype wire
